// File: rtl/sha1_pkg.sv
// SHA-1 engine shared types, round constants and initial chaining values.
// No dependencies; imported by the message schedule, round unit and top modules.
package sha1_pkg;

	typedef logic [31:0] word_t;

	localparam int unsigned ROUNDS = 80;

	localparam word_t K0 = 32'h5A827999;
	localparam word_t K1 = 32'h6ED9EBA1;
	localparam word_t K2 = 32'h8F1BBCDC;
	localparam word_t K3 = 32'hCA62C1D6;

	localparam logic [4:0][31:0] IV = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	localparam logic [7:0] PAD_BYTE  = 8'h80;
	localparam logic [5:0] FILL_LAST = 6'd63;
	localparam logic [5:0] LEN_POS   = 6'd56;
	localparam logic [6:0] RND_LAST  = 7'(ROUNDS - 1);

	typedef struct packed {
		logic init;
		logic load;
		logic step;
		logic add;
	} rnd_ctrl_t;

	typedef struct packed {
		logic       wr;
		logic [5:0] idx;
		logic [7:0] data;
		logic       shift;
	} ws_ctrl_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_COMP = 5'b00010,
		ST_ADD  = 5'b00100,
		ST_PAD  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	function automatic word_t rotl(word_t x, int unsigned n);
		return (x << n) | (x >> (32 - n));
	endfunction

endpackage

// File: rtl/sha1_wsched.sv
// SHA-1 block buffer and message schedule: 16-word shift line with byte writes.
// Depends on sha1_pkg.
module sha1_wsched import sha1_pkg::*; (
	input  logic     clk,
	input  ws_ctrl_t ctrl,
	output word_t    w_cur
);

	logic [15:0][3:0][7:0] w_q;
	word_t                 w_new;

	assign w_new = rotl(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0], 1);
	assign w_cur = w_q[0];

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			for (int k = 0; k < 15; k++) begin
				w_q[k] <= w_q[k+1];
			end
			w_q[15] <= w_new;
		end else if (ctrl.wr) begin
			w_q[ctrl.idx[5:2]][2'd3 - ctrl.idx[1:0]] <= ctrl.data;
		end
	end

endmodule

// File: rtl/sha1_round.sv
// SHA-1 round unit: working variables, one round per step, and chaining words.
// Depends on sha1_pkg.
module sha1_round import sha1_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  rnd_ctrl_t        ctrl,
	input  logic [6:0]       rnd,
	input  word_t            w,
	output logic [4:0][31:0] chain
);

	word_t            a_q, b_q, c_q, d_q, e_q;
	word_t            f, k, t;
	logic [4:0][31:0] chain_q;

	always_comb begin
		priority if (rnd < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = K0;
		end else if (rnd < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = K1;
		end else if (rnd < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K3;
		end
	end

	assign t     = rotl(a_q, 5) + f + e_q + w + k;
	assign chain = chain_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (ctrl.step) begin
			e_q <= d_q;
			d_q <= c_q;
			c_q <= rotl(b_q, 30);
			b_q <= a_q;
			a_q <= t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= IV;
		end else if (ctrl.init) begin
			chain_q <= IV;
		end else if (ctrl.add) begin
			chain_q[0] <= chain_q[0] + a_q;
			chain_q[1] <= chain_q[1] + b_q;
			chain_q[2] <= chain_q[2] + c_q;
			chain_q[3] <= chain_q[3] + d_q;
			chain_q[4] <= chain_q[4] + e_q;
		end
	end

endmodule

// File: rtl/sha1_hash_engine_top.sv
// SHA-1 engine top: bytes are taken while idle; every 64th byte starts a block of
// 80 rounds on the one round unit plus the chaining add. A last transaction pads one
// byte per cycle up to the block end and compresses it; when the length does not fit,
// a second pad block follows. After an overflow of the bit count no padding is done.
// Then the result register loads, held off while an earlier result is still stalled.
// Reset (arst_n low, async) clears control and loads the initial chaining words.
module sha1_hash_engine_top import sha1_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // data_byte
	input  logic         s_axis_tuser,   // byte_valid
	input  logic         s_axis_tlast,   // last
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [159:0] m_axis_tdata,   // digest_h0, digest_h1, digest_h2, digest_h3, digest_h4
	output logic         m_axis_tuser    // status
);

	state_t           state_q;
	logic [5:0]       fill_q, fill_nx;
	logic [63:0]      bit_cnt_q, cnt_nx;
	logic             ovf_q, ovf_nx;
	logic [6:0]       rnd_q;
	logic             last_pend_q, pad_act_q, pad_first_q, len_ph_q;
	logic             out_valid_q, out_stat_q;
	logic [159:0]     out_data_q;
	logic             in_acc, take, comp_go, fin_go;
	logic [7:0][7:0]  len_bytes;
	logic [7:0]       pad_byte;
	ws_ctrl_t         ws_ctrl;
	rnd_ctrl_t        rnd_ctrl;
	word_t            w_cur;
	logic [4:0][31:0] chain;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_stat_q;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign take    = in_acc && s_axis_tuser && !ovf_q;
	assign cnt_nx  = bit_cnt_q + 64'd8;
	assign ovf_nx  = ovf_q || (take && (cnt_nx == 64'd0));
	assign fill_nx = fill_q + 6'd1;
	assign comp_go = ((state_q == ST_IDLE) && take && (fill_q == FILL_LAST)) ||
	                 ((state_q == ST_PAD) && (fill_q == FILL_LAST));
	assign fin_go  = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);

	assign len_bytes = bit_cnt_q;

	always_comb begin
		priority if (pad_first_q) begin
			pad_byte = PAD_BYTE;
		end else if (len_ph_q && (fill_q >= LEN_POS)) begin
			pad_byte = len_bytes[3'd7 - fill_q[2:0]];
		end else begin
			pad_byte = 8'h00;
		end
	end

	always_comb begin
		ws_ctrl.wr    = take || (state_q == ST_PAD);
		ws_ctrl.idx   = fill_q;
		ws_ctrl.data  = take ? s_axis_tdata : pad_byte;
		ws_ctrl.shift = (state_q == ST_COMP);
		rnd_ctrl.init = fin_go;
		rnd_ctrl.load = comp_go;
		rnd_ctrl.step = (state_q == ST_COMP);
		rnd_ctrl.add  = (state_q == ST_ADD);
	end

	sha1_wsched u_wsched (
		.clk   (clk),
		.ctrl  (ws_ctrl),
		.w_cur (w_cur)
	);

	sha1_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (rnd_ctrl),
		.rnd    (rnd_q),
		.w      (w_cur),
		.chain  (chain)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			bit_cnt_q   <= '0;
			ovf_q       <= 1'b0;
			rnd_q       <= '0;
			last_pend_q <= 1'b0;
			pad_act_q   <= 1'b0;
			pad_first_q <= 1'b0;
			len_ph_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						bit_cnt_q <= cnt_nx;
						fill_q    <= fill_nx;
						ovf_q     <= ovf_nx;
					end
					if (take && (fill_q == FILL_LAST)) begin
						state_q     <= ST_COMP;
						rnd_q       <= '0;
						last_pend_q <= s_axis_tlast;
						pad_act_q   <= 1'b0;
					end else if (in_acc && s_axis_tlast) begin
						if (ovf_nx) begin
							state_q <= ST_FIN;
						end else begin
							state_q     <= ST_PAD;
							pad_first_q <= 1'b1;
							pad_act_q   <= 1'b1;
							len_ph_q    <= (take ? fill_nx : fill_q) < LEN_POS;
						end
					end
				end
				ST_COMP: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == RND_LAST) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					if (pad_act_q) begin
						if (len_ph_q) begin
							state_q <= ST_FIN;
						end else begin
							state_q  <= ST_PAD;
							len_ph_q <= 1'b1;
						end
					end else if (last_pend_q) begin
						last_pend_q <= 1'b0;
						if (ovf_q) begin
							state_q <= ST_FIN;
						end else begin
							state_q     <= ST_PAD;
							pad_first_q <= 1'b1;
							pad_act_q   <= 1'b1;
							len_ph_q    <= 1'b1;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_PAD: begin
					fill_q      <= fill_nx;
					pad_first_q <= 1'b0;
					if (fill_q == FILL_LAST) begin
						state_q <= ST_COMP;
						rnd_q   <= '0;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						fill_q      <= '0;
						bit_cnt_q   <= '0;
						ovf_q       <= 1'b0;
						last_pend_q <= 1'b0;
						pad_act_q   <= 1'b0;
						pad_first_q <= 1'b0;
						len_ph_q    <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_stat_q <= ovf_q;
			out_data_q <= ovf_q ? 160'd0 : chain;
		end
	end

endmodule

// File: rtl/sha1_hash_engine_chk.sv
// Port-level checker for the SHA-1 engine, bound to the top level.
// Depends on sha1_hash_engine_top ports only.
module sha1_hash_engine_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic [7:0]   s_axis_tdata,
	input logic         s_axis_tuser,
	input logic         s_axis_tlast,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [159:0] m_axis_tdata,
	input logic         m_axis_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser))
		else $error("result changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 160'd0)
		else $error("error status with nonzero digest");

	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("ready right after last transaction");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result appeared without finishing phase");

endmodule

bind sha1_hash_engine_top sha1_hash_engine_chk u_chk (.*);
